// ===== src/cbld_pkg.sv =====
// Shared types, constants and helpers of the CSR edge builder.
`default_nettype none
package cbld_pkg;
	localparam int NodeAw    = 10;
	localparam int SlotW     = 14;
	localparam int NumW      = 36;
	localparam int DenW      = 13;
	localparam int CostW     = 31;
	localparam int CfgW      = 11;
	localparam int DivSteps  = NumW;
	localparam int DivCntW   = 6;
	localparam logic [CfgW-1:0] MaxNodes = 11'd1024;

	// input command codes
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_COUNT  = 3'd1;
	localparam logic [2:0] CMD_FINISH = 3'd2;
	localparam logic [2:0] CMD_PLACE  = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	typedef enum logic [2:0] {
		OP_CLEAR, OP_COUNT, OP_FINISH, OP_PLACE, OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [NodeAw-1:0] from_node;
		logic [NodeAw-1:0] to_node;
		logic [11:0]       seg;
		logic [NumW-1:0]   num;
		logic [DenW-1:0]   den;
		logic              fwd_open;
		logic              bwd_open;
	} item_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_CLR,
		ST_CNT_RDF, ST_CNT_WRF, ST_CNT_RDT, ST_CNT_WRT,
		ST_FIN_RD, ST_FIN_WR, ST_FIN_END,
		ST_DIV,
		ST_PL_RDF, ST_PL_WRF, ST_PL_OUTF, ST_PL_RDT, ST_PL_WRT, ST_PL_OUTT,
		ST_RD_RD, ST_RD_OUT
	} state_t;

	// 25 * speed, with unknown speed taken as 5 km/h
	function automatic logic [DenW-1:0] speed_den(input logic [7:0] kph);
		logic [DenW-1:0] s;
		s = (kph == 8'd0) ? DenW'(5) : {5'b0, kph};
		return (s << 4) + (s << 3) + s;
	endfunction
endpackage
`default_nettype wire

// ===== src/cbld_front.sv =====
// Front end: accept commands, classify them and build queue entries.
`default_nettype none
module cbld_front (
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          command,
	input  wire logic [9:0]          from_node,
	input  wire logic [9:0]          to_node,
	input  wire logic [11:0]         segment_index,
	input  wire logic [31:0]         length_cm,
	input  wire logic [7:0]          free_flow_kph,
	input  wire logic [7:0]          route_class,
	input  wire logic [7:0]          access_mask,
	input  wire logic                oneway_forward,
	input  wire logic                oneway_backward,
	input  wire logic                q_full,
	input  wire logic                busy,
	output logic                     push,
	output cbld_pkg::item_t          item
);
	logic routable;
	logic keep;
	logic [cbld_pkg::NumW-1:0] len_ext;

	assign in_stall = q_full | busy;
	assign routable = (route_class != 8'd0) && (access_mask != 8'd0);
	assign len_ext  = {4'b0, length_cm};

	// classify; drop commands that leave no trace
	always_comb begin
		item.from_node = from_node;
		item.to_node   = to_node;
		item.seg       = segment_index;
		item.num       = (len_ext << 3) + len_ext;
		item.den       = cbld_pkg::speed_den(free_flow_kph);
		item.fwd_open  = ~oneway_backward;
		item.bwd_open  = ~oneway_forward;
		item.op        = cbld_pkg::OP_CLEAR;
		keep           = 1'b0;
		unique case (command)
			cbld_pkg::CMD_CLEAR: begin
				keep = 1'b1;
			end
			cbld_pkg::CMD_COUNT: begin
				item.op = cbld_pkg::OP_COUNT;
				keep    = routable & (~oneway_backward | ~oneway_forward);
			end
			cbld_pkg::CMD_FINISH: begin
				item.op = cbld_pkg::OP_FINISH;
				keep    = 1'b1;
			end
			cbld_pkg::CMD_PLACE: begin
				item.op = cbld_pkg::OP_PLACE;
				keep    = routable & (~oneway_backward | ~oneway_forward);
			end
			cbld_pkg::CMD_READ: begin
				item.op = cbld_pkg::OP_READ;
				keep    = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = in_valid & ~in_stall & keep;
endmodule
`default_nettype wire

// ===== src/cbld_fifo.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none
module cbld_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cbld_pkg::item_t wdata,
	input  wire logic            pop,
	output cbld_pkg::item_t      rdata,
	output logic                 empty,
	output logic                 full
);
	cbld_pkg::item_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign rdata = ent_q[rd_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/cbld_div.sv =====
// Restoring divider, one quotient bit per cycle, for the travel cost.
`default_nettype none
module cbld_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [cbld_pkg::NumW-1:0]  num,
	input  wire logic [cbld_pkg::DenW-1:0]  den,
	output logic                            done,
	output logic [cbld_pkg::CostW-1:0]      quo
);
	logic [cbld_pkg::NumW-1:0]    num_q;
	logic [cbld_pkg::DenW-1:0]    den_q;
	logic [cbld_pkg::DenW-1:0]    rem_q;
	logic [cbld_pkg::DivCntW-1:0] cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [cbld_pkg::DenW:0]      sh;
	logic [cbld_pkg::DenW:0]      diff;
	logic                         ge;

	assign sh   = {rem_q, num_q[cbld_pkg::NumW-1]};
	assign ge   = (sh >= {1'b0, den_q});
	assign diff = sh - {1'b0, den_q};
	assign done = done_q;
	assign quo  = num_q[cbld_pkg::CostW-1:0];

	// shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[cbld_pkg::DenW-1:0] : sh[cbld_pkg::DenW-1:0];
			num_q <= {num_q[cbld_pkg::NumW-2:0], ge};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cbld_pkg::DivCntW'(cbld_pkg::DivSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/cbld_back.sv =====
// Back end: sequencer over the degree and offset memories, output register.
`default_nettype none
module cbld_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [10:0]              cfg_wr_data,
	input  wire cbld_pkg::item_t          head,
	input  wire logic                     empty,
	output logic                          pop,
	output logic                          busy,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          kind,
	output logic [13:0]                   slot,
	output logic [11:0]                   edge_segment,
	output logic [9:0]                    target_node,
	output logic [30:0]                   cost_ds,
	output logic                          forward,
	output logic                          last
);
	localparam int Depth = 2 ** cbld_pkg::NodeAw;

	cbld_pkg::state_t state_q, state_d;
	cbld_pkg::item_t  it_q;

	logic [cbld_pkg::SlotW-1:0] deg_mem [Depth];
	logic [cbld_pkg::SlotW-1:0] off_mem [Depth];

	logic [cbld_pkg::CfgW-1:0]   node_count_q;
	logic [cbld_pkg::CfgW-1:0]   lim_q;
	logic [cbld_pkg::CfgW-1:0]   lim_d;
	logic [cbld_pkg::CfgW-1:0]   ptr_q;
	logic [cbld_pkg::SlotW-1:0]  run_q;
	logic [cbld_pkg::SlotW-1:0]  rdata_q;
	logic [cbld_pkg::SlotW-1:0]  odata_q;
	logic [cbld_pkg::SlotW-1:0]  slot_q;
	logic [cbld_pkg::CostW-1:0]  cost_q;

	logic                        deg_we, off_we;
	logic [cbld_pkg::NodeAw-1:0] deg_wa, off_wa, deg_ra, off_ra;
	logic [cbld_pkg::SlotW-1:0]  deg_wd, off_wd;
	logic                        div_start, div_done;
	logic [cbld_pkg::CostW-1:0]  div_quo;
	logic                        space;
	logic                        ld;
	logic                        sweep_end;

	cbld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (head.num),
		.den    (head.den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign space     = ~out_valid | ~out_stall;
	assign busy      = (state_q == cbld_pkg::ST_INIT);
	assign lim_d     = (node_count_q > cbld_pkg::MaxNodes) ? cbld_pkg::MaxNodes : node_count_q;
	assign sweep_end = (ptr_q[cbld_pkg::NodeAw-1:0] == {cbld_pkg::NodeAw{1'b1}});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbld_pkg::ST_INIT, cbld_pkg::ST_CLR: begin
				if (sweep_end) state_d = cbld_pkg::ST_IDLE;
			end
			cbld_pkg::ST_IDLE: begin
				if (!empty) begin
					unique case (head.op)
						cbld_pkg::OP_CLEAR:  state_d = cbld_pkg::ST_CLR;
						cbld_pkg::OP_COUNT:  state_d = head.fwd_open ? cbld_pkg::ST_CNT_RDF
						                                             : cbld_pkg::ST_CNT_RDT;
						cbld_pkg::OP_FINISH: state_d = (lim_d == '0) ? cbld_pkg::ST_FIN_END
						                                             : cbld_pkg::ST_FIN_RD;
						cbld_pkg::OP_PLACE:  state_d = cbld_pkg::ST_DIV;
						cbld_pkg::OP_READ:   state_d = cbld_pkg::ST_RD_RD;
						default:             state_d = cbld_pkg::ST_IDLE;
					endcase
				end
			end
			cbld_pkg::ST_CNT_RDF: state_d = cbld_pkg::ST_CNT_WRF;
			cbld_pkg::ST_CNT_WRF: state_d = it_q.bwd_open ? cbld_pkg::ST_CNT_RDT
			                                              : cbld_pkg::ST_IDLE;
			cbld_pkg::ST_CNT_RDT: state_d = cbld_pkg::ST_CNT_WRT;
			cbld_pkg::ST_CNT_WRT: state_d = cbld_pkg::ST_IDLE;
			cbld_pkg::ST_FIN_RD:  state_d = cbld_pkg::ST_FIN_WR;
			cbld_pkg::ST_FIN_WR: begin
				state_d = (ptr_q + 11'd1 == lim_q) ? cbld_pkg::ST_FIN_END
				                                   : cbld_pkg::ST_FIN_RD;
			end
			cbld_pkg::ST_FIN_END: state_d = cbld_pkg::ST_IDLE;
			cbld_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = it_q.fwd_open ? cbld_pkg::ST_PL_RDF : cbld_pkg::ST_PL_RDT;
				end
			end
			cbld_pkg::ST_PL_RDF: state_d = cbld_pkg::ST_PL_WRF;
			cbld_pkg::ST_PL_WRF: state_d = cbld_pkg::ST_PL_OUTF;
			cbld_pkg::ST_PL_OUTF: begin
				if (space) state_d = it_q.bwd_open ? cbld_pkg::ST_PL_RDT : cbld_pkg::ST_IDLE;
			end
			cbld_pkg::ST_PL_RDT: state_d = cbld_pkg::ST_PL_WRT;
			cbld_pkg::ST_PL_WRT: state_d = cbld_pkg::ST_PL_OUTT;
			cbld_pkg::ST_PL_OUTT, cbld_pkg::ST_RD_OUT: begin
				if (space) state_d = cbld_pkg::ST_IDLE;
			end
			cbld_pkg::ST_RD_RD: state_d = cbld_pkg::ST_RD_OUT;
			default: state_d = cbld_pkg::ST_IDLE;
		endcase
	end

	// memory ports, queue pop, output load
	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		ld        = 1'b0;
		deg_we    = 1'b0;
		off_we    = 1'b0;
		deg_wa    = ptr_q[cbld_pkg::NodeAw-1:0];
		off_wa    = ptr_q[cbld_pkg::NodeAw-1:0];
		deg_wd    = '0;
		off_wd    = '0;
		deg_ra    = it_q.from_node;
		off_ra    = it_q.from_node;
		unique case (state_q) inside
			cbld_pkg::ST_INIT: begin
				deg_we = 1'b1;
				off_we = 1'b1;
			end
			cbld_pkg::ST_IDLE: begin
				pop       = ~empty;
				div_start = ~empty && (head.op == cbld_pkg::OP_PLACE);
			end
			cbld_pkg::ST_CLR: begin
				deg_we = 1'b1;
			end
			cbld_pkg::ST_CNT_WRF, cbld_pkg::ST_PL_WRF: begin
				deg_we = 1'b1;
				deg_wa = it_q.from_node;
				deg_wd = rdata_q + 14'd1;
			end
			cbld_pkg::ST_CNT_RDT, cbld_pkg::ST_PL_RDT: begin
				deg_ra = it_q.to_node;
			end
			cbld_pkg::ST_CNT_WRT, cbld_pkg::ST_PL_WRT: begin
				deg_we = 1'b1;
				deg_wa = it_q.to_node;
				deg_wd = rdata_q + 14'd1;
			end
			cbld_pkg::ST_FIN_RD: begin
				deg_ra = ptr_q[cbld_pkg::NodeAw-1:0];
			end
			cbld_pkg::ST_FIN_WR: begin
				deg_we = 1'b1;
				off_we = 1'b1;
				deg_wd = run_q;
				off_wd = run_q;
			end
			cbld_pkg::ST_FIN_END: begin
				// the entry past the last node lives only below the full table size
				deg_we = ~lim_q[cbld_pkg::NodeAw];
				off_we = ~lim_q[cbld_pkg::NodeAw];
				deg_wa = lim_q[cbld_pkg::NodeAw-1:0];
				off_wa = lim_q[cbld_pkg::NodeAw-1:0];
				deg_wd = run_q;
				off_wd = run_q;
			end
			cbld_pkg::ST_PL_OUTF, cbld_pkg::ST_PL_OUTT, cbld_pkg::ST_RD_OUT: begin
				ld = space;
			end
			default: begin
			end
		endcase
	end

	// memories with registered read
	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		rdata_q <= deg_mem[deg_ra];
	end

	always_ff @(posedge clk) begin
		if (off_we) off_mem[off_wa] <= off_wd;
		odata_q <= off_mem[off_ra];
	end

	// working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			it_q  <= head;
			lim_q <= lim_d;
			run_q <= '0;
		end
		if (state_q == cbld_pkg::ST_FIN_WR) run_q <= run_q + rdata_q;
		if (state_q == cbld_pkg::ST_PL_WRF || state_q == cbld_pkg::ST_PL_WRT) begin
			slot_q <= rdata_q;
		end
		if (state_q == cbld_pkg::ST_DIV && div_done) begin
			cost_q <= (div_quo == '0) ? cbld_pkg::CostW'(1) : div_quo;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ld) begin
			unique case (state_q) inside
				cbld_pkg::ST_PL_OUTF, cbld_pkg::ST_PL_OUTT: begin
					kind         <= 1'b0;
					slot         <= slot_q;
					edge_segment <= it_q.seg;
					cost_ds      <= cost_q;
					if (state_q == cbld_pkg::ST_PL_OUTF) begin
						target_node <= it_q.to_node;
						forward     <= 1'b1;
						last        <= ~it_q.bwd_open;
					end else begin
						target_node <= it_q.from_node;
						forward     <= 1'b0;
						last        <= 1'b1;
					end
				end
				default: begin
					kind         <= 1'b1;
					slot         <= odata_q;
					edge_segment <= '0;
					target_node  <= '0;
					cost_ds      <= '0;
					forward      <= 1'b0;
					last         <= 1'b1;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cbld_pkg::ST_INIT;
			ptr_q        <= '0;
			node_count_q <= '0;
			out_valid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) node_count_q <= cfg_wr_data;
			if (state_q == cbld_pkg::ST_IDLE) begin
				ptr_q <= '0;
			end else if (state_q == cbld_pkg::ST_INIT || state_q == cbld_pkg::ST_CLR ||
			             state_q == cbld_pkg::ST_FIN_WR) begin
				ptr_q <= ptr_q + 11'd1;
			end
			if (ld) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/csr_edge_builder_top.sv =====
// CSR edge builder: front end, command queue and memory back end.
// After reset a pass over every address zeroes both memories; input stalls meanwhile.
// Place: bit-serial division, then a read, write and output step per edge, each edge
// waiting for the output register. One command runs in the back end at a time;
// a two-entry queue lets the front end keep taking commands meanwhile.
`default_nettype none
module csr_edge_builder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [9:0]  from_node,
	input  wire logic [9:0]  to_node,
	input  wire logic [11:0] segment_index,
	input  wire logic [31:0] length_cm,
	input  wire logic [7:0]  free_flow_kph,
	input  wire logic [7:0]  route_class,
	input  wire logic [7:0]  access_mask,
	input  wire logic        oneway_forward,
	input  wire logic        oneway_backward,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [13:0]      slot,
	output logic [11:0]      edge_segment,
	output logic [9:0]       target_node,
	output logic [30:0]      cost_ds,
	output logic             forward,
	output logic             last
);
	cbld_pkg::item_t push_item;
	cbld_pkg::item_t head_item;
	logic push, pop, empty, full, busy;

	cbld_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.from_node       (from_node),
		.to_node         (to_node),
		.segment_index   (segment_index),
		.length_cm       (length_cm),
		.free_flow_kph   (free_flow_kph),
		.route_class     (route_class),
		.access_mask     (access_mask),
		.oneway_forward  (oneway_forward),
		.oneway_backward (oneway_backward),
		.q_full          (full),
		.busy            (busy),
		.push            (push),
		.item            (push_item)
	);

	cbld_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_item),
		.pop    (pop),
		.rdata  (head_item),
		.empty  (empty),
		.full   (full)
	);

	cbld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.head         (head_item),
		.empty        (empty),
		.pop          (pop),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.slot         (slot),
		.edge_segment (edge_segment),
		.target_node  (target_node),
		.cost_ds      (cost_ds),
		.forward      (forward),
		.last         (last)
	);
endmodule
`default_nettype wire

// ===== src/cbld_checker.sv =====
// Port-level checks of the CSR edge builder, bound to the top level.
`default_nettype none
module cbld_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        kind,
	input wire logic [13:0] slot,
	input wire logic [9:0]  target_node,
	input wire logic [30:0] cost_ds,
	input wire logic        forward,
	input wire logic        last
);
	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// an offset result is a single, otherwise empty transfer
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last && cost_ds == 31'd0 && target_node == 10'd0 && !forward)
		else $error("malformed offset result");

	// every edge costs at least one decisecond
	a_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> cost_ds != 31'd0)
		else $error("edge with zero cost");

	// an edge result that is not marked last must be the forward one
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind && !last |-> forward)
		else $error("reverse edge not last");
endmodule

bind csr_edge_builder_top cbld_checker u_cbld_checker (.*);
`default_nettype wire

// ===== tb/csr_edge_builder_top_tb.sv =====
// Self-checking testbench of the CSR edge builder with its own CSR predictor.
`default_nettype none
module csr_edge_builder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES      = 1024;
	localparam int DRAIN_WAIT = 6000;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [2:0]  command;
		logic [9:0]  from_node;
		logic [9:0]  to_node;
		logic [11:0] segment_index;
		logic [31:0] length_cm;
		logic [7:0]  free_flow_kph;
		logic [7:0]  route_class;
		logic [7:0]  access_mask;
		logic        oneway_forward;
		logic        oneway_backward;
	} segment_cmd_t;

	typedef struct {
		logic        kind;
		logic [13:0] slot;
		logic [11:0] edge_segment;
		logic [9:0]  target_node;
		logic [30:0] cost_ds;
		logic        forward;
		logic        last;
	} csr_result_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic in_valid, in_stall;
	logic [2:0] command;
	logic [9:0] from_node, to_node;
	logic [11:0] segment_index;
	logic [31:0] length_cm;
	logic [7:0] free_flow_kph, route_class, access_mask;
	logic oneway_forward, oneway_backward;
	logic out_valid, out_stall;
	logic kind, forward, last;
	logic [13:0] slot;
	logic [11:0] edge_segment;
	logic [9:0] target_node;
	logic [30:0] cost_ds;

	// predictor state
	logic [13:0] degree_model [0:NODES];
	logic [13:0] offset_model [0:NODES];
	logic [10:0] node_count_model;
	csr_result_t pending_results [$];

	int idle_pct, stall_pct;
	int errors, items_sent, results_seen, idle_cycles;

	csr_edge_builder_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .from_node(from_node), .to_node(to_node),
		.segment_index(segment_index), .length_cm(length_cm),
		.free_flow_kph(free_flow_kph), .route_class(route_class),
		.access_mask(access_mask), .oneway_forward(oneway_forward),
		.oneway_backward(oneway_backward),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .slot(slot), .edge_segment(edge_segment),
		.target_node(target_node), .cost_ds(cost_ds),
		.forward(forward), .last(last)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// work out the results of one accepted command and advance the model
	task automatic predict_csr(input segment_cmd_t c);
		logic routable, fwd_open, bwd_open;
		logic [63:0] quot;
		logic [30:0] cost;
		logic [13:0] running, d;
		int cnt;
		csr_result_t r;
		routable = (c.route_class != 0) && (c.access_mask != 0);
		fwd_open = !c.oneway_backward;
		bwd_open = !c.oneway_forward;
		case (c.command)
			cbld_pkg::CMD_CLEAR: begin
				for (int i = 0; i <= NODES; i++) degree_model[i] = '0;
			end
			cbld_pkg::CMD_COUNT: begin
				if (routable) begin
					if (fwd_open) degree_model[c.from_node] = degree_model[c.from_node] + 14'd1;
					if (bwd_open) degree_model[c.to_node] = degree_model[c.to_node] + 14'd1;
				end
			end
			cbld_pkg::CMD_FINISH: begin
				cnt = (node_count_model > NODES) ? NODES : node_count_model;
				running = '0;
				for (int i = 0; i < cnt; i++) begin
					d = degree_model[i];
					offset_model[i] = running;
					degree_model[i] = running;
					running = running + d;
				end
				offset_model[cnt] = running;
				degree_model[cnt] = running;
			end
			cbld_pkg::CMD_PLACE: begin
				if (routable) begin
					quot = ({32'b0, c.length_cm} * 64'd9) /
						(64'd25 * ((c.free_flow_kph == 0) ? 64'd5 : 64'(c.free_flow_kph)));
					if (quot < 1) quot = 1;
					cost = quot[30:0];
					r.kind = 1'b0;
					r.edge_segment = c.segment_index;
					r.cost_ds = cost;
					if (fwd_open) begin
						r.slot = degree_model[c.from_node];
						degree_model[c.from_node] = degree_model[c.from_node] + 14'd1;
						r.target_node = c.to_node;
						r.forward = 1'b1;
						r.last = !bwd_open;
						pending_results.insert(pending_results.size(), r);
					end
					if (bwd_open) begin
						r.slot = degree_model[c.to_node];
						degree_model[c.to_node] = degree_model[c.to_node] + 14'd1;
						r.target_node = c.from_node;
						r.forward = 1'b0;
						r.last = 1'b1;
						pending_results.insert(pending_results.size(), r);
					end
				end
			end
			cbld_pkg::CMD_READ: begin
				r = '{1'b1, offset_model[c.from_node], '0, '0, '0, 1'b0, 1'b1};
				pending_results.insert(pending_results.size(), r);
			end
			default: ;
		endcase
	endtask

	// drive one command, hold it until the transfer completes
	task automatic send_cmd(input segment_cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c.command;
		from_node <= c.from_node;
		to_node <= c.to_node;
		segment_index <= c.segment_index;
		length_cm <= c.length_cm;
		free_flow_kph <= c.free_flow_kph;
		route_class <= c.route_class;
		access_mask <= c.access_mask;
		oneway_forward <= c.oneway_forward;
		oneway_backward <= c.oneway_backward;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_csr(c);
		items_sent++;
	endtask

	function automatic segment_cmd_t make_cmd(input logic [2:0] op, input logic [9:0] a,
			input logic [9:0] b, input logic fo, input logic bo);
		segment_cmd_t c;
		c.command = op;
		c.from_node = a;
		c.to_node = b;
		c.segment_index = 12'($urandom);
		c.length_cm = $urandom_range(0, 2000000);
		c.free_flow_kph = 8'($urandom);
		c.route_class = 8'($urandom_range(1, 255));
		c.access_mask = 8'($urandom_range(1, 255));
		c.oneway_forward = fo;
		c.oneway_backward = bo;
		return c;
	endfunction

	// wait for every result, let silent commands finish, then write the register
	task automatic set_node_count(input logic [10:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		node_count_model = v;
	endtask

	// hand-picked commands: each operation, field extremes and special cases
	task automatic test_directed();
		segment_cmd_t c;
		idle_pct = 0;
		stall_pct = 0;
		send_cmd(make_cmd(cbld_pkg::CMD_READ, 10'd0, 10'd0, 0, 0));
		send_cmd(make_cmd(cbld_pkg::CMD_READ, 10'd1023, 10'd0, 0, 0));
		set_node_count(11'd5);
		send_cmd(make_cmd(cbld_pkg::CMD_CLEAR, 0, 0, 0, 0));
		send_cmd(make_cmd(cbld_pkg::CMD_COUNT, 10'd0, 10'd1, 0, 0));
		send_cmd(make_cmd(cbld_pkg::CMD_COUNT, 10'd1, 10'd3, 1, 0));
		send_cmd(make_cmd(cbld_pkg::CMD_COUNT, 10'd3, 10'd2, 0, 1));
		send_cmd(make_cmd(cbld_pkg::CMD_COUNT, 10'd4, 10'd0, 1, 1));
		c = make_cmd(cbld_pkg::CMD_COUNT, 10'd2, 10'd4, 0, 0);
		c.route_class = 0;
		send_cmd(c);
		c.route_class = 8'hFF;
		c.access_mask = 0;
		send_cmd(c);
		send_cmd(make_cmd(cbld_pkg::CMD_FINISH, 0, 0, 0, 0));
		// cost extremes: zero length, unknown speed at a near-maximum length, all-ones length
		c = make_cmd(cbld_pkg::CMD_PLACE, 10'd0, 10'd1, 0, 0);
		c.length_cm = 0;
		c.free_flow_kph = 8'hFF;
		c.segment_index = 12'hFFF;
		send_cmd(c);
		c = make_cmd(cbld_pkg::CMD_PLACE, 10'd1, 10'd3, 1, 0);
		c.length_cm = 32'd4000000000;
		c.free_flow_kph = 0;
		send_cmd(c);
		c = make_cmd(cbld_pkg::CMD_PLACE, 10'd3, 10'd2, 0, 1);
		c.length_cm = 32'hFFFFFFFF;
		c.free_flow_kph = 8'd1;
		c.segment_index = 0;
		send_cmd(c);
		send_cmd(make_cmd(cbld_pkg::CMD_PLACE, 10'd4, 10'd0, 1, 1));
		c = make_cmd(cbld_pkg::CMD_PLACE, 10'd2, 10'd4, 0, 0);
		c.access_mask = 0;
		send_cmd(c);
		for (int i = 0; i <= 5; i++) send_cmd(make_cmd(cbld_pkg::CMD_READ, 10'(i), 0, 0, 0));
		for (int k = 1; k <= 3; k++)
			send_cmd(make_cmd(cbld_pkg::CMD_READ + 3'(k), 10'd3, 10'd3, 0, 0));
		send_cmd(make_cmd(cbld_pkg::CMD_READ, 10'd1023, 0, 0, 0));
	endtask

	// one full build: clear, count, finish, place the same segments, read back
	task automatic run_build(input int max_node, input int nsegs);
		segment_cmd_t segs [$];
		segment_cmd_t c;
		send_cmd(make_cmd(cbld_pkg::CMD_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < nsegs; i++) begin
			c = make_cmd(cbld_pkg::CMD_COUNT, 10'($urandom_range(0, max_node)),
				10'($urandom_range(0, max_node)),
				$urandom_range(3) == 0, $urandom_range(3) == 0);
			if ($urandom_range(9) == 0) c.route_class = 0;
			if ($urandom_range(9) == 0) c.access_mask = 0;
			if ($urandom_range(3) == 0) c.length_cm = $urandom;
			segs.insert(segs.size(), c);
			send_cmd(c);
		end
		send_cmd(make_cmd(cbld_pkg::CMD_FINISH, 0, 0, 0, 0));
		foreach (segs[i]) begin
			c = segs[i];
			c.command = cbld_pkg::CMD_PLACE;
			send_cmd(c);
		end
		for (int i = 0; i < nsegs / 2; i++)
			send_cmd(make_cmd(cbld_pkg::CMD_READ, 10'($urandom_range(0, max_node + 1)), 0, 0, 0));
	endtask

	// raw commands with every field random, unknown codes included
	task automatic run_noise(input int n);
		segment_cmd_t c;
		for (int i = 0; i < n; i++) begin
			c.command = 3'($urandom);
			c.from_node = 10'($urandom);
			c.to_node = 10'($urandom);
			c.segment_index = 12'($urandom);
			c.length_cm = $urandom;
			c.free_flow_kph = 8'($urandom);
			c.route_class = 8'($urandom_range(3) == 0 ? 0 : $urandom);
			c.access_mask = 8'($urandom_range(3) == 0 ? 0 : $urandom);
			c.oneway_forward = 1'($urandom);
			c.oneway_backward = 1'($urandom);
			send_cmd(c);
		end
	endtask

	task automatic test_random_phases();
		int ipct [4] = '{0, 54, 0, 21};
		int spct [4] = '{0, 0, 54, 21};
		logic [10:0] counts [4] = '{11'd1024, 11'd16, 11'd2047, 11'd0};
		for (int p = 0; p < 4; p++) begin
			set_node_count(p == 1 ? 11'($urandom_range(2, 40)) : counts[p]);
			idle_pct = ipct[p];
			stall_pct = spct[p];
			run_build(p == 1 ? 30 : 1023, 20);
			run_build(12, 14);
			run_noise(30);
			idle_pct = 0;
			stall_pct = 0;
			run_build(6, 15);
		end
	endtask

	// receiver: stall at the rate of the current phase
	always @(posedge clk)
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		csr_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind=%0d slot=%0d seg=%0d tgt=%0d cost=%0d fwd=%0d last=%0d",
					$time, kind, slot, edge_segment, target_node, cost_ds, forward, last);
			end else begin
				e = pending_results.pop_front();
				if (e.kind !== kind || e.slot !== slot || e.edge_segment !== edge_segment ||
						e.target_node !== target_node || e.cost_ds !== cost_ds ||
						e.forward !== forward || e.last !== last) begin
					errors++;
					$display("%0t: mismatch expected kind=%0d slot=%0d seg=%0d tgt=%0d cost=%0d fwd=%0d last=%0d",
						$time, e.kind, e.slot, e.edge_segment, e.target_node, e.cost_ds,
						e.forward, e.last);
					$display("%0t:          actual kind=%0d slot=%0d seg=%0d tgt=%0d cost=%0d fwd=%0d last=%0d",
						$time, kind, slot, edge_segment, target_node, cost_ds, forward, last);
				end
			end
		end
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL csr_edge_builder_top");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		command = '0;
		from_node = '0;
		to_node = '0;
		segment_index = '0;
		length_cm = '0;
		free_flow_kph = '0;
		route_class = '0;
		access_mask = '0;
		oneway_forward = 1'b0;
		oneway_backward = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		node_count_model = '0;
		for (int i = 0; i <= NODES; i++) begin
			degree_model[i] = '0;
			offset_model[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_phases();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d commands and %0d result transfers over builds at node counts 0..2047,",
			items_sent, results_seen);
		$display("with sender gaps and receiver stalls; %0d mismatches.", errors);
		if (errors == 0)
			$display("PASS csr_edge_builder_top");
		else
			$display("FAIL csr_edge_builder_top");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
src/cbld_pkg.sv
src/cbld_front.sv
src/cbld_fifo.sv
src/cbld_div.sv
src/cbld_back.sv
src/csr_edge_builder_top.sv
src/cbld_checker.sv
tb/csr_edge_builder_top_tb.sv
